FILE: design/scrs_pkg.sv
// Shared types, constants and SHA-256 round helpers for the cascade round search.
// No dependencies; used by design/sha256_cascade_round_search.sv.
`default_nettype none

package scrs_pkg;

	typedef logic [31:0] word_t;

	// Round constant K[60]
	localparam word_t ROUND_K60 = 32'h90befffa;

	// Sweep width; held to the range 1..32
	localparam int SCAN_BITS = 16;
	localparam int SCAN_W = (SCAN_BITS < 1) ? 1 : ((SCAN_BITS > 32) ? 32 : SCAN_BITS);

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		choose = (e & f) ^ (~e & g);
	endfunction

	function automatic word_t majority(input word_t a, input word_t b, input word_t c);
		majority = (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

`default_nettype wire

FILE: design/sha256_cascade_round_search.sv
// Top level of the SHA-256 cascade round search: item capture, per-item setup,
// candidate sweep through a four-stage pipeline and result register. Uses scrs_pkg.
`default_nettype none

// One item is taken at a time; in_stall is high from acceptance until its result
// has been moved into the output register, which may still hold the previous
// result while a new item is accepted. An item passes through three setup states
// (PREP1, PREP2, PREP3), then the sweep issues one candidate word per cycle into a
// four-stage checker pipeline. Without a match all 2^SCAN_W candidates are issued
// and the pipeline drains before the result is registered, and the next item can
// be taken in the following cycle; a match ends the sweep early and flushes the
// candidates still in flight.
module sha256_cascade_round_search (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] pair_a,
	input  wire logic [63:0] pair_b,
	input  wire logic [63:0] pair_c,
	input  wire logic [63:0] pair_d,
	input  wire logic [63:0] pair_e,
	input  wire logic [63:0] pair_f,
	input  wire logic [63:0] pair_g,
	input  wire logic [63:0] pair_h,
	input  wire logic [31:0] word_offset,
	input  wire logic [31:0] target_difference,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             found
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP1 = 3'd1;
	localparam logic [2:0] ST_PREP2 = 3'd2;
	localparam logic [2:0] ST_PREP3 = 3'd3;
	localparam logic [2:0] ST_SWEEP = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;

	// Item registers, index 0 is the first state, 1 the second
	scrs_pkg::word_t a_q [2];
	scrs_pkg::word_t b_q [2];
	scrs_pkg::word_t c_q [2];
	scrs_pkg::word_t d_q [2];
	scrs_pkg::word_t e_q [2];
	scrs_pkg::word_t f_q [2];
	scrs_pkg::word_t g_q [2];
	scrs_pkg::word_t h_q [2];
	scrs_pkg::word_t off_q;
	scrs_pkg::word_t tgt_q;

	// Setup terms; ka/ke end as the per-item constants added to the candidate
	scrs_pkg::word_t pa_q [2];
	scrs_pkg::word_t pb_q [2];
	scrs_pkg::word_t t2_q [2];
	scrs_pkg::word_t ka_q [2];
	scrs_pkg::word_t ke_q [2];

	logic [scrs_pkg::SCAN_W-1:0] cnt_q;
	logic                        found_q;

	// Pipeline registers
	logic            v_s1, v_s2, v_s3, v_s4;
	scrs_pkg::word_t na_s1 [2];
	scrs_pkg::word_t ne_s1 [2];
	scrs_pkg::word_t ds_s2, dc_s2, tp_s2, tq_s2;
	scrs_pkg::word_t u_s3, tv_s3;
	logic            hit_s4;

	logic            in_take;
	logic            out_take;
	logic            issue;
	logic            hit;
	logic            pipe_busy;
	logic            load_out;
	scrs_pkg::word_t w_cand;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid && !out_stall;
	assign issue     = (state_q == ST_SWEEP);
	assign hit       = v_s4 && hit_s4;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign load_out  = (state_q == ST_DONE) && (!out_valid || !out_stall);
	assign w_cand    = 32'(cnt_q);

	// Control: state, sweep counter, pipeline valids, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// a match flushes whatever is still in flight
			v_s1 <= issue && !hit;
			v_s2 <= v_s1 && !hit;
			v_s3 <= v_s2 && !hit;
			v_s4 <= v_s3 && !hit;
			out_valid <= load_out || (out_valid && !out_take);
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_PREP1;
					end
				end
				ST_PREP1: state_q <= ST_PREP2;
				ST_PREP2: state_q <= ST_PREP3;
				ST_PREP3: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP, ST_DRAIN: begin
					if (state_q == ST_SWEEP) begin
						cnt_q <= cnt_q + 1'b1;
						if (&cnt_q) begin
							state_q <= ST_DRAIN;
						end
					end
					if (hit) begin
						// first match ends the sweep
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (state_q == ST_DRAIN && !pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found <= found_q;
		end
	end

	// Item capture and per-item setup
	always_ff @(posedge clk) begin
		if (in_take) begin
			a_q[0] <= pair_a[63:32];
			a_q[1] <= pair_a[31:0];
			b_q[0] <= pair_b[63:32];
			b_q[1] <= pair_b[31:0];
			c_q[0] <= pair_c[63:32];
			c_q[1] <= pair_c[31:0];
			d_q[0] <= pair_d[63:32];
			d_q[1] <= pair_d[31:0];
			e_q[0] <= pair_e[63:32];
			e_q[1] <= pair_e[31:0];
			f_q[0] <= pair_f[63:32];
			f_q[1] <= pair_f[31:0];
			g_q[0] <= pair_g[63:32];
			g_q[1] <= pair_g[31:0];
			h_q[0] <= pair_h[63:32];
			h_q[1] <= pair_h[31:0];
			off_q  <= word_offset;
			tgt_q  <= target_difference;
		end
		if (state_q == ST_PREP1) begin
			// target less the h difference of the new states (old g)
			tgt_q <= tgt_q - g_q[0] + g_q[1];
			for (int i = 0; i < 2; i++) begin
				pa_q[i] <= h_q[i] + scrs_pkg::big_sigma1(e_q[i]);
				t2_q[i] <= scrs_pkg::big_sigma0(a_q[i])
					+ scrs_pkg::majority(a_q[i], b_q[i], c_q[i]);
			end
			pb_q[0] <= scrs_pkg::choose(e_q[0], f_q[0], g_q[0]) + scrs_pkg::ROUND_K60;
			pb_q[1] <= scrs_pkg::choose(e_q[1], f_q[1], g_q[1]) + scrs_pkg::ROUND_K60
				+ off_q;
		end
		if (state_q == ST_PREP2) begin
			// t1 without the candidate word
			for (int i = 0; i < 2; i++) begin
				pa_q[i] <= pa_q[i] + pb_q[i];
			end
		end
		if (state_q == ST_PREP3) begin
			for (int i = 0; i < 2; i++) begin
				ka_q[i] <= pa_q[i] + t2_q[i];
				ke_q[i] <= pa_q[i] + d_q[i];
			end
		end
	end

	// Checker pipeline: new a and e, then the difference terms, then sum and compare
	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			na_s1[i] <= ka_q[i] + w_cand;
			ne_s1[i] <= ke_q[i] + w_cand;
		end
		ds_s2 <= scrs_pkg::big_sigma1(ne_s1[0]) - scrs_pkg::big_sigma1(ne_s1[1]);
		dc_s2 <= scrs_pkg::choose(ne_s1[0], e_q[0], f_q[0])
			- scrs_pkg::choose(ne_s1[1], e_q[1], f_q[1]);
		tp_s2 <= scrs_pkg::big_sigma0(na_s1[0])
			+ scrs_pkg::majority(na_s1[0], a_q[0], b_q[0]);
		tq_s2 <= scrs_pkg::big_sigma0(na_s1[1])
			+ scrs_pkg::majority(na_s1[1], a_q[1], b_q[1]);
		u_s3   <= ds_s2 + dc_s2;
		tv_s3  <= tp_s2 - tq_s2;
		hit_s4 <= ((u_s3 + tv_s3) == tgt_q);
	end

endmodule

`default_nettype wire
